// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the consumer revision table RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain invariant, checked at every rising edge out of reset.
`define CRT_ASSERT(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication.
`define CRT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define CRT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/crt_pkg.sv =====
// Shared types and constants for the consumer revision table.
// No dependencies; compile before every other file of the block.
`timescale 1ns / 1ps

package crt_pkg;

    localparam int ID_W  = 32;
    localparam int REV_W = 64;

    typedef enum logic [1:0] {
        CMD_ATTACH  = 2'd0,
        CMD_PRESENT = 2'd1,
        CMD_DETACH  = 2'd2,
        CMD_QUERY   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_ZERO_ID      = 3'd1,
        ST_DUPLICATE    = 3'd2,
        ST_NOT_ATTACHED = 3'd3,
        ST_BACKWARDS    = 3'd4,
        ST_FULL         = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        CTL_IDLE   = 3'b001,
        CTL_SCAN   = 3'b010,
        CTL_COMMIT = 3'b100
    } ctl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic start;
        logic scan;
        logic commit;
    } ctl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic scan_done;
        logic out_busy;
    } dp_sts_t;

endpackage

// ===== hdl/crt_req_if.sv =====
// Request channel of the consumer revision table: valid/ready plus payload.
// Depends on crt_pkg.
`timescale 1ns / 1ps

interface crt_req_if;
    logic                        valid;
    logic                        ready;
    crt_pkg::cmd_t               cmd;
    logic [crt_pkg::ID_W-1:0]    view_id;
    logic [crt_pkg::REV_W-1:0]   revision;

    modport source (output valid, cmd, view_id, revision, input ready);
    modport sink   (input valid, cmd, view_id, revision, output ready);
endinterface

// ===== hdl/crt_rsp_if.sv =====
// Response channel of the consumer revision table: valid/ready plus payload.
// Depends on crt_pkg.
`timescale 1ns / 1ps

interface crt_rsp_if;
    logic                        valid;
    logic                        ready;
    crt_pkg::status_t            status;
    logic [crt_pkg::ID_W-1:0]    out_id;
    logic [crt_pkg::REV_W-1:0]   out_revision;
    logic [crt_pkg::REV_W-1:0]   min_revision;

    modport source (output valid, status, out_id, out_revision, min_revision, input ready);
    modport sink   (input valid, status, out_id, out_revision, min_revision, output ready);
endinterface

// ===== hdl/crt_ctrl.sv =====
// Sequencer of the consumer revision table: accept, scan, commit.
// Depends on crt_pkg.
`timescale 1ns / 1ps

module crt_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  crt_pkg::dp_sts_t  sts,
    output crt_pkg::ctl_cmd_t ctl
);

    crt_pkg::ctl_state_t state_reg;
    crt_pkg::ctl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            crt_pkg::CTL_IDLE:
            begin
                in_ready  = 1'b1;
                ctl.start = in_valid;
                if (in_valid)
                begin
                    state_next = crt_pkg::CTL_SCAN;
                end
            end
            crt_pkg::CTL_SCAN:
            begin
                ctl.scan = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = crt_pkg::CTL_COMMIT;
                end
            end
            crt_pkg::CTL_COMMIT:
            begin
                // hold until the result register is free
                if (!sts.out_busy)
                begin
                    ctl.commit = 1'b1;
                    state_next = crt_pkg::CTL_IDLE;
                end
            end
            default:
            begin
                state_next = crt_pkg::CTL_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= crt_pkg::CTL_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/crt_datapath.sv =====
// Datapath of the consumer revision table: entry memories, valid bits,
// scan accumulators and result register. Depends on crt_pkg.
`timescale 1ns / 1ps

module crt_datapath
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  crt_pkg::ctl_cmd_t           ctl,
    output crt_pkg::dp_sts_t            sts,
    input  crt_pkg::cmd_t               req_cmd,
    input  logic [crt_pkg::ID_W-1:0]    req_view_id,
    input  logic [crt_pkg::REV_W-1:0]   req_revision,
    output logic                        out_valid,
    input  logic                        out_ready,
    output crt_pkg::status_t            out_status,
    output logic [crt_pkg::ID_W-1:0]    out_id,
    output logic [crt_pkg::REV_W-1:0]   out_revision,
    output logic [crt_pkg::REV_W-1:0]   min_revision
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(MAX_ENTRIES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ENTRIES - 1);

    // entry storage
    logic [crt_pkg::ID_W-1:0]  id_mem  [MAX_ENTRIES];
    logic [crt_pkg::REV_W-1:0] rev_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0]    valid_reg, valid_next;

    // latched request
    crt_pkg::cmd_t             cmd_reg, cmd_next;
    logic [crt_pkg::ID_W-1:0]  id_reg, id_next;
    logic [crt_pkg::REV_W-1:0] rev_reg, rev_next;

    // scan pointer and compare stage
    logic [CNT_W-1:0]          rd_cnt_reg, rd_cnt_next;
    logic                      cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]          cmp_idx_reg, cmp_idx_next;
    logic [crt_pkg::ID_W-1:0]  id_rd_reg;
    logic [crt_pkg::REV_W-1:0] rev_rd_reg;

    // scan accumulators
    logic                      hit_reg, hit_next;
    logic [IDX_W-1:0]          hit_idx_reg, hit_idx_next;
    logic [crt_pkg::REV_W-1:0] hit_rev_reg, hit_rev_next;
    logic                      free_reg, free_next;
    logic [IDX_W-1:0]          free_idx_reg, free_idx_next;
    logic                      oth_any_reg, oth_any_next;
    logic [crt_pkg::REV_W-1:0] oth_min_reg, oth_min_next;

    // result register
    logic                      out_valid_reg, out_valid_next;
    crt_pkg::status_t          out_status_reg;
    logic [crt_pkg::ID_W-1:0]  out_id_reg;
    logic [crt_pkg::REV_W-1:0] out_rev_reg;
    logic [crt_pkg::REV_W-1:0] out_min_reg;

    logic                      rd_en;
    logic [IDX_W-1:0]          rd_idx;
    logic                      slot_valid;
    logic                      slot_match;

    crt_pkg::status_t          res_status;
    logic [crt_pkg::REV_W-1:0] res_rev;
    logic [crt_pkg::REV_W-1:0] res_min;
    logic                      wr_ok;
    logic                      mem_we;
    logic [IDX_W-1:0]          wr_idx;
    logic                      set_v;
    logic                      clr_v;
    logic                      inc;
    logic [crt_pkg::REV_W-1:0] inc_val;

    assign rd_en      = ctl.scan && (rd_cnt_reg != CNT_END);
    assign rd_idx     = rd_cnt_reg[IDX_W-1:0];
    assign slot_valid = valid_reg[cmp_idx_reg];
    assign slot_match = slot_valid && (id_rd_reg == id_reg);

    assign sts.scan_done = ctl.scan && cmp_vld_reg && (cmp_idx_reg == IDX_LAST);
    assign sts.out_busy  = out_valid_reg && !out_ready;

    // Scan: one slot read per cycle, each compared in the following cycle.
    always_comb
    begin
        cmd_next      = cmd_reg;
        id_next       = id_reg;
        rev_next      = rev_reg;
        rd_cnt_next   = rd_cnt_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        hit_rev_next  = hit_rev_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        oth_any_next  = oth_any_reg;
        oth_min_next  = oth_min_reg;
        if (ctl.start)
        begin
            cmd_next     = req_cmd;
            id_next      = req_view_id;
            rev_next     = req_revision;
            rd_cnt_next  = '0;
            hit_next     = 1'b0;
            free_next    = 1'b0;
            oth_any_next = 1'b0;
        end
        else if (ctl.scan)
        begin
            cmp_vld_next = rd_en;
            cmp_idx_next = rd_idx;
            if (rd_en)
            begin
                rd_cnt_next = rd_cnt_reg + CNT_W'(1);
            end
            if (cmp_vld_reg)
            begin
                if (slot_match)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                    hit_rev_next = rev_rd_reg;
                end
                if (!slot_valid && !free_reg)
                begin
                    free_next     = 1'b1;
                    free_idx_next = cmp_idx_reg;
                end
                // minimum over every attached entry except the matching one
                if (slot_valid && !slot_match && (!oth_any_reg || rev_rd_reg < oth_min_reg))
                begin
                    oth_any_next = 1'b1;
                    oth_min_next = rev_rd_reg;
                end
            end
        end
    end

    // Decide the outcome from the scan results.
    always_comb
    begin
        res_status = crt_pkg::ST_OK;
        res_rev    = '0;
        wr_ok      = 1'b0;
        wr_idx     = hit_idx_reg;
        set_v      = 1'b0;
        clr_v      = 1'b0;
        inc        = 1'b0;
        inc_val    = hit_rev_reg;
        unique case (cmd_reg)
            crt_pkg::CMD_ATTACH:
            begin
                if (id_reg == '0)
                begin
                    res_status = crt_pkg::ST_ZERO_ID;
                end
                else if (hit_reg)
                begin
                    res_status = crt_pkg::ST_DUPLICATE;
                    inc        = 1'b1;
                end
                else if (!free_reg)
                begin
                    res_status = crt_pkg::ST_FULL;
                end
                else
                begin
                    wr_ok   = 1'b1;
                    wr_idx  = free_idx_reg;
                    set_v   = 1'b1;
                    res_rev = rev_reg;
                    inc     = 1'b1;
                    inc_val = rev_reg;
                end
            end
            crt_pkg::CMD_PRESENT:
            begin
                if (!hit_reg)
                begin
                    res_status = crt_pkg::ST_NOT_ATTACHED;
                end
                else if (rev_reg < hit_rev_reg)
                begin
                    res_status = crt_pkg::ST_BACKWARDS;
                    inc        = 1'b1;
                end
                else
                begin
                    wr_ok   = 1'b1;
                    res_rev = rev_reg;
                    inc     = 1'b1;
                    inc_val = rev_reg;
                end
            end
            crt_pkg::CMD_DETACH:
            begin
                if (!hit_reg)
                begin
                    res_status = crt_pkg::ST_NOT_ATTACHED;
                end
                else
                begin
                    clr_v = 1'b1;
                end
            end
            crt_pkg::CMD_QUERY:
            begin
                if (!hit_reg)
                begin
                    res_status = crt_pkg::ST_NOT_ATTACHED;
                end
                else
                begin
                    res_rev = hit_rev_reg;
                    inc     = 1'b1;
                end
            end
        endcase

        if (inc && (!oth_any_reg || inc_val < oth_min_reg))
        begin
            res_min = inc_val;
        end
        else if (oth_any_reg)
        begin
            res_min = oth_min_reg;
        end
        else
        begin
            res_min = '0;
        end
    end

    assign mem_we = ctl.commit && wr_ok;

    always_comb
    begin
        valid_next = valid_reg;
        if (ctl.commit && set_v)
        begin
            valid_next[wr_idx] = 1'b1;
        end
        if (ctl.commit && clr_v)
        begin
            valid_next[wr_idx] = 1'b0;
        end
    end

    always_comb
    begin
        if (ctl.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // entry memories: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            id_mem[wr_idx]  <= id_reg;
            rev_mem[wr_idx] <= rev_reg;
        end
        if (rd_en)
        begin
            id_rd_reg  <= id_mem[rd_idx];
            rev_rd_reg <= rev_mem[rd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            cmd_reg       <= crt_pkg::CMD_QUERY;
            rd_cnt_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            oth_any_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg     <= valid_next;
            cmd_reg       <= cmd_next;
            rd_cnt_reg    <= rd_cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            oth_any_reg   <= oth_any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        id_reg       <= id_next;
        rev_reg      <= rev_next;
        cmp_idx_reg  <= cmp_idx_next;
        hit_idx_reg  <= hit_idx_next;
        hit_rev_reg  <= hit_rev_next;
        free_idx_reg <= free_idx_next;
        oth_min_reg  <= oth_min_next;
        if (ctl.commit)
        begin
            out_status_reg <= res_status;
            out_id_reg     <= id_reg;
            out_rev_reg    <= res_rev;
            out_min_reg    <= res_min;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_id       = out_id_reg;
    assign out_revision = out_rev_reg;
    assign min_revision = out_min_reg;

endmodule

// ===== hdl/consumer_revision_table_top.sv =====
// Top level of the consumer revision table: sequencer plus datapath.
// Depends on crt_pkg, crt_req_if, crt_rsp_if, crt_ctrl, crt_datapath and
// assert_macros.svh.
//
//  channel  dir  handshake        payload
//  -------  ---  ---------------  ------------------------------------------
//  req      in   valid / ready    cmd, view_id, revision
//  rsp      out  valid / ready    status, out_id, out_revision, min_revision
//
// Each item is accepted in the idle state, then scanned over every slot in
// the scan state, one slot read per cycle over a single read port and each
// read compared in the cycle after, then written to its result register in
// the commit state. The next item is accepted only once the sequencer is back
// in the idle state, so items do not overlap; a waiting response does not
// hold off the next scan, but a commit stalls while the result register still
// holds an untaken item. Reset clears every valid bit at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module consumer_revision_table_top
#(
    parameter int MAX_ENTRIES = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    crt_req_if.sink   req,
    crt_rsp_if.source rsp
);

    crt_pkg::ctl_cmd_t ctl;
    crt_pkg::dp_sts_t  sts;

    // sequencer: owns the request handshake
    crt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .ctl      (ctl)
    );

    // datapath: table storage, scan and the response register
    crt_datapath
    #(
        .MAX_ENTRIES (MAX_ENTRIES)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .req_cmd      (req.cmd),
        .req_view_id  (req.view_id),
        .req_revision (req.revision),
        .out_valid    (rsp.valid),
        .out_ready    (rsp.ready),
        .out_status   (rsp.status),
        .out_id       (rsp.out_id),
        .out_revision (rsp.out_revision),
        .min_revision (rsp.min_revision)
    );

    // never overwrite a result that is still waiting
    `CRT_ASSERT_IMP(a_commit_free, ctl.commit, !(rsp.valid && !rsp.ready), "commit over a held result")
    // a commit always presents a result in the next cycle
    `CRT_ASSERT_NXT(a_commit_shows, ctl.commit, rsp.valid, "commit without a result")
    // no item is taken while a scan is in progress
    `CRT_ASSERT_IMP(a_accept_idle, req.valid && req.ready, !ctl.scan && !ctl.commit, "accept during scan")

endmodule

// ===== test/consumer_revision_table_checker.sv =====
// Scoreboard for the consumer revision table: watches both channels, keeps a
// shadow copy of the table, predicts each response and compares it field by field.
// Depends on crt_pkg, crt_req_if and crt_rsp_if.
`timescale 1ns / 1ps

module consumer_revision_table_checker
#(
    parameter int DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    crt_req_if   req,
    crt_rsp_if   rsp,
    output int   fails,
    output int   pending
);

    localparam int ID_W  = crt_pkg::ID_W;
    localparam int REV_W = crt_pkg::REV_W;

    typedef struct {
        crt_pkg::status_t status;
        logic [ID_W-1:0]  id;
        logic [REV_W-1:0] rev;
        logic [REV_W-1:0] low_rev;
    } table_result_t;

    // Shadow of the table contents
    bit               slot_used [DEPTH];
    logic [ID_W-1:0]  slot_id   [DEPTH];
    logic [REV_W-1:0] slot_rev  [DEPTH];

    table_result_t due_q [$];
    int            mismatch_count = 0;

    assign fails = mismatch_count;

    initial
    begin
        pending = 0;
        foreach (slot_used[i])
        begin
            slot_used[i] = 1'b0;
            slot_id[i]   = '0;
            slot_rev[i]  = '0;
        end
    end

    task automatic report(string msg);
        $display("[%0t] checker: %s", $time, msg);
        mismatch_count++;
    endtask

    // Apply one request to the shadow table and return the response it must give.
    function automatic table_result_t apply_request(crt_pkg::cmd_t c, logic [ID_W-1:0] id,
                                                    logic [REV_W-1:0] rv);
        table_result_t r;
        int            hit;
        int            free_at;
        bit            seen;
        hit     = -1;
        free_at = -1;
        seen    = 1'b0;
        r.status  = crt_pkg::ST_OK;
        r.id      = id;
        r.rev     = '0;
        r.low_rev = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (slot_used[i] && slot_id[i] == id && hit < 0)
                hit = i;
            if (!slot_used[i] && free_at < 0)
                free_at = i;
        end
        case (c)
            crt_pkg::CMD_ATTACH:
                if (id == '0)
                    r.status = crt_pkg::ST_ZERO_ID;
                else if (hit >= 0)
                    r.status = crt_pkg::ST_DUPLICATE;
                else if (free_at < 0)
                    r.status = crt_pkg::ST_FULL;
                else
                begin
                    slot_used[free_at] = 1'b1;
                    slot_id[free_at]   = id;
                    slot_rev[free_at]  = rv;
                    r.rev              = rv;
                end
            crt_pkg::CMD_PRESENT:
                if (hit < 0)
                    r.status = crt_pkg::ST_NOT_ATTACHED;
                else if (rv < slot_rev[hit])
                    r.status = crt_pkg::ST_BACKWARDS;
                else
                begin
                    slot_rev[hit] = rv;
                    r.rev         = rv;
                end
            crt_pkg::CMD_DETACH:
                if (hit < 0)
                    r.status = crt_pkg::ST_NOT_ATTACHED;
                else
                    slot_used[hit] = 1'b0;
            default:
                if (hit < 0)
                    r.status = crt_pkg::ST_NOT_ATTACHED;
                else
                    r.rev = slot_rev[hit];
        endcase
        for (int i = 0; i < DEPTH; i++)
        begin
            if (slot_used[i] && (!seen || slot_rev[i] < r.low_rev))
            begin
                r.low_rev = slot_rev[i];
                seen      = 1'b1;
            end
        end
        return r;
    endfunction

    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n)
        begin
            // A response never belongs to the request taken at the same edge,
            // so retire before predicting.
            if (rsp.valid && rsp.ready)
            begin
                if (due_q.size() == 0)
                    report($sformatf("response with nothing outstanding (id %h)", rsp.out_id));
                else
                begin
                    want = due_q.pop_front();
                    if (rsp.status !== want.status)
                        report($sformatf("status %0d, expected %s (id %h)",
                                         rsp.status, want.status.name(), want.id));
                    if (rsp.out_id !== want.id)
                        report($sformatf("out_id %h, expected %h", rsp.out_id, want.id));
                    if (rsp.out_revision !== want.rev)
                        report($sformatf("out_revision %h, expected %h (id %h)",
                                         rsp.out_revision, want.rev, want.id));
                    if (rsp.min_revision !== want.low_rev)
                        report($sformatf("min_revision %h, expected %h (id %h)",
                                         rsp.min_revision, want.low_rev, want.id));
                end
            end
            if (req.valid && req.ready)
                due_q.push_back(apply_request(req.cmd, req.view_id, req.revision));
            pending = due_q.size();
        end
    end

endmodule

// ===== test/consumer_revision_table_top_tb.sv =====
// Testbench top for the consumer revision table: clock, reset, request stimulus,
// response back-pressure, watchdog and verdict. Depends on crt_pkg, both channel
// interfaces, the block and consumer_revision_table_checker.
`timescale 1ns / 1ps

module consumer_revision_table_top_tb;

    localparam int ID_W        = crt_pkg::ID_W;
    localparam int REV_W       = crt_pkg::REV_W;
    localparam int TABLE_DEPTH = 16;
    localparam int POOL_SIZE   = 24;
    localparam int PHASES      = 4;
    localparam int PHASE_ITEMS = 170;
    // Longest correct silence: the long receiver hold-off plus one item's
    // scan and a sender gap, taken several times over.
    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 240;

    logic clk;
    logic rst_n;
    int   chk_fails;
    int   chk_pending;
    bit   holdoff_go;

    // Candidate ids for random traffic, and the last revision offered for each,
    // so that presents mostly move forwards.
    logic [ID_W-1:0]  id_pool  [POOL_SIZE];
    logic [REV_W-1:0] rev_hint [POOL_SIZE];

    crt_req_if req_ch ();
    crt_rsp_if rsp_ch ();

    consumer_revision_table_top #(
        .MAX_ENTRIES (TABLE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    consumer_revision_table_checker #(
        .DEPTH (TABLE_DEPTH)
    ) u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .fails   (chk_fails),
        .pending (chk_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hold the request at a falling edge until the block takes it, then return
    // at the next falling edge with valid still high.
    task automatic offer(crt_pkg::cmd_t c, logic [ID_W-1:0] id, logic [REV_W-1:0] rv);
        req_ch.valid    <= 1'b1;
        req_ch.cmd      <= c;
        req_ch.view_id  <= id;
        req_ch.revision <= rv;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop valid for a pause of length n; n of zero keeps the stream back to back.
    task automatic pause_sender(int n);
        if (n > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every outstanding response has come back.
    task automatic drain;
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (chk_pending != 0)
            @(negedge clk);
    endtask

    // Draw one request, weighted towards ids the table is likely to hold.
    task automatic draw_request(output crt_pkg::cmd_t c, output logic [ID_W-1:0] id,
                                output logic [REV_W-1:0] rv);
        int pick;
        int slot;
        int roll;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, POOL_SIZE - 1);
        roll = $urandom_range(0, 99);
        if (pick < 30)
            c = crt_pkg::CMD_ATTACH;
        else if (pick < 65)
            c = crt_pkg::CMD_PRESENT;
        else if (pick < 80)
            c = crt_pkg::CMD_DETACH;
        else
            c = crt_pkg::CMD_QUERY;

        pick = $urandom_range(0, 99);
        if (pick < 4)
            id = '0;
        else if (pick < 12)
            id = $urandom;
        else
            id = id_pool[slot];

        if (roll < 15)
            rv = {$urandom, $urandom};
        else if (c == crt_pkg::CMD_PRESENT && roll < 35)
            rv = rev_hint[slot] - 64'($urandom_range(1, 50));
        else if (c == crt_pkg::CMD_ATTACH && roll < 40)
            rv = 64'($urandom_range(0, 1000));
        else
            rv = rev_hint[slot] + 64'($urandom_range(0, 3));

        // Track the high-water mark only for traffic that can move it.
        if (id == id_pool[slot] && (c == crt_pkg::CMD_ATTACH || rv >= rev_hint[slot]))
            rev_hint[slot] = rv;
    endtask

    // Stimulus: reset, a directed pass over every status, then random phases.
    initial
    begin
        crt_pkg::cmd_t    c;
        logic [ID_W-1:0]  id;
        logic [REV_W-1:0] rv;
        int               sent;
        int               burst;

        rst_n           = 1'b0;
        holdoff_go      = 1'b0;
        req_ch.valid    = 1'b0;
        req_ch.cmd      = crt_pkg::CMD_QUERY;
        req_ch.view_id  = '0;
        req_ch.revision = '0;

        // The first fifteen pool ids match the directed fill below, so the random part
        // can detach them again; entry 15 takes the all-ones id, the rest are random.
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            id_pool[i]  = (i < 15) ? ID_W'(i + 2) : ID_W'($urandom);
            rev_hint[i] = 64'(100 + i);
        end
        id_pool[15] = '1;
        rev_hint[15] = '1;

        repeat (2) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: empty table, zero id, extreme id and revision, duplicate,
        // equal and backward presents, detach of a present and an absent id.
        offer(crt_pkg::CMD_QUERY,   32'd5, '0);
        offer(crt_pkg::CMD_ATTACH,  '0,    64'd7);
        offer(crt_pkg::CMD_ATTACH,  '1,    '1);
        offer(crt_pkg::CMD_ATTACH,  '1,    64'd3);
        offer(crt_pkg::CMD_ATTACH,  32'd1, '0);
        offer(crt_pkg::CMD_PRESENT, 32'd1, '0);
        offer(crt_pkg::CMD_PRESENT, '1,    64'd5);
        offer(crt_pkg::CMD_DETACH,  32'd1, '0);
        offer(crt_pkg::CMD_DETACH,  32'd1, '0);
        // Fill the remaining fifteen slots, then overflow the table.
        for (int i = 2; i <= 16; i++)
            offer(crt_pkg::CMD_ATTACH, ID_W'(i), 64'(100 + i));
        offer(crt_pkg::CMD_ATTACH, 32'd17, 64'd42);
        drain();

        // Random phases; each ends with the sender paused until all responses
        // are back. Trigger the long receiver hold-off during the second one.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 1)
                holdoff_go = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS)
            begin
                burst = $urandom_range(1, 16);
                for (int b = 0; b < burst; b++)
                begin
                    draw_request(c, id, rv);
                    offer(c, id, rv);
                    sent++;
                end
                // Leave a quarter of bursts joined so long gapless runs occur.
                if ($urandom_range(0, 3) != 0)
                    pause_sender($urandom_range(1, 12));
            end
            drain();
        end

        // Let any late or spurious response surface before the verdict.
        repeat (40) @(negedge clk);
        if (chk_fails == 0 && chk_pending == 0)
            $display("consumer_revision_table_top_tb passed");
        else
            $display("consumer_revision_table_top_tb failed");
        $finish;
    end

    // Response side: stall on a pattern of modes (always ready, coin toss,
    // mostly stalled), and hold off once for a long stretch so the block fills
    // up and stops taking requests.
    initial
    begin
        int  mode;
        int  mode_left;
        int  hold_left;
        bit  held;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        held      = 1'b0;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holdoff_go && !held)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                case (mode)
                    0:       rsp_ch.ready <= 1'b1;
                    1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                    default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Watchdog: end the run if neither channel moves an item for too long.
    initial
    begin
        int idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle = 0;
            else
                idle++;
        end
        $display("consumer_revision_table_top_tb failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/crt_pkg.sv
hdl/crt_req_if.sv
hdl/crt_rsp_if.sv
hdl/crt_ctrl.sv
hdl/crt_datapath.sv
hdl/consumer_revision_table_top.sv
test/consumer_revision_table_checker.sv
test/consumer_revision_table_top_tb.sv
